FILE: sv/assert_macros.svh
// Assertion macros used by the checker of the Q table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define QLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/qlt_pkg.sv
// Package of the Q table block: sizes, payload types, register codes and index helpers.
package qlt_pkg;

    localparam int GRID_SIDE   = 4;
    localparam int NUM_ACTIONS = 4;
    localparam int NUM_STATES  = GRID_SIDE * GRID_SIDE;
    localparam int Q_DEPTH     = NUM_STATES * NUM_ACTIONS;

    localparam int STATE_W = $clog2(NUM_STATES);
    localparam int ACT_W   = $clog2(NUM_ACTIONS);
    localparam int ADDR_W  = $clog2(Q_DEPTH);

    // Fixed field widths of the beats
    localparam int IN_STATE_W  = 4;
    localparam int IN_ACT_W    = 2;
    localparam int OUT_ACT_W   = 2;
    localparam int VAL_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int Q_W         = 18;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [Q_W-1:0]   Q_MAX      = 18'h3FFFF;
    localparam logic [CFG_W-1:0] LR_RESET   = 16'd6554;
    localparam logic [CFG_W-1:0] DISC_RESET = 16'd64881;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] ONE_FIX = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'd1;

    typedef struct packed {
        logic                  req_type;
        logic [IN_STATE_W-1:0] cur_state;
        logic [IN_ACT_W-1:0]   taken_action;
        logic [VAL_W-1:0]      reward_in;
        logic [IN_STATE_W-1:0] next_state;
        logic [VAL_W-1:0]      explore_rate;
        logic [VAL_W-1:0]      explore_draw;
        logic [IN_ACT_W-1:0]   random_action;
    } t_in_item;

    typedef struct packed {
        logic [OUT_ACT_W-1:0] chosen_action;
        logic                 explored;
        logic [Q_W-1:0]       new_q_value;
    } t_out_item;

    // Control of the row scanner, one beat of read data per cycle
    typedef struct packed {
        logic             en;
        logic             first;
        logic [ACT_W-1:0] idx;
    } t_scan_ctl;

    function automatic logic [STATE_W-1:0] wrap_state(input logic [IN_STATE_W-1:0] v);
        logic [STATE_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << IN_STATE_W); k++) begin
            if (v == IN_STATE_W'(k)) begin
                r = STATE_W'(k % NUM_STATES);
            end
        end
        return r;
    endfunction

    function automatic logic [ACT_W-1:0] wrap_action(input logic [IN_ACT_W-1:0] v);
        logic [ACT_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << IN_ACT_W); k++) begin
            if (v == IN_ACT_W'(k)) begin
                r = ACT_W'(k % NUM_ACTIONS);
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] q_addr(input logic [STATE_W-1:0] s,
                                                 input logic [ACT_W-1:0] a);
        return ADDR_W'(s) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a);
    endfunction

endpackage

FILE: sv/qlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qlt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/qlt_mul.sv
// Shared unsigned multiplier with a registered product.
module qlt_mul import qlt_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_op_a,
    input  logic [MUL_B_W-1:0] i_op_b,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_op_a) * MUL_P_W'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/qlt_scan.sv
// Running maximum and lowest-index argmax over one row of the Q table.
module qlt_scan import qlt_pkg::*; (
    input  logic             i_clk,
    input  t_scan_ctl        i_ctl,
    input  logic [Q_W-1:0]   i_data,
    output logic [Q_W-1:0]   o_best,
    output logic [ACT_W-1:0] o_best_idx
);

    logic [Q_W-1:0]   r_best;
    logic [ACT_W-1:0] r_best_idx;

    // Strict compare keeps the earlier action on a tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && (i_ctl.first || (i_data > r_best))) begin
            r_best     <= i_data;
            r_best_idx <= i_ctl.idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

FILE: sv/q_learning_table_update.sv
// Top level of the Q table engine: sequencer, table, shared multiplier and scanner.
//
//  channel   | direction | handshake                  | beat
//  ----------+-----------+----------------------------+------------------------------
//  request   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  result    | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  config    | in        | i_cfg_we, no back-pressure | i_cfg_idx, i_cfg_data
//
//  An update request scans two rows and a select request one, each scan making one
//  table read per cycle on the single read port; an update also makes three passes
//  through the one multiplier. A new request is taken the cycle after the result is
//  loaded.
//  Reset clears the state, the per-entry valid bits (so the whole table reads zero
//  at once) and reloads the rate registers; no clearing pass is needed.
//  A stalled result beat holds the finished item in the output register; the
//  sequencer waits before loading the next one until that beat leaves.
module q_learning_table_update import qlt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDQ  = 4'd1;   // read Q(s,a)
    localparam logic [3:0] S_ROW  = 4'd2;   // read next-state row for the max
    localparam logic [3:0] S_ROWW = 4'd3;   // drain last row beat
    localparam logic [3:0] S_M1   = 4'd4;   // gamma * max
    localparam logic [3:0] S_M2   = 4'd5;   // target, Q * (1 - lr)
    localparam logic [3:0] S_M3   = 4'd6;   // keep, lr * target
    localparam logic [3:0] S_M4   = 4'd7;   // sum and saturate
    localparam logic [3:0] S_WR   = 4'd8;   // write back
    localparam logic [3:0] S_SEL  = 4'd9;   // read row for the greedy pick
    localparam logic [3:0] S_SELW = 4'd10;  // drain last row beat
    localparam logic [3:0] S_OUT  = 4'd11;  // load result register

    logic [3:0]         r_state, n_state;
    logic [ACT_W-1:0]   r_cnt, n_cnt;
    logic [CFG_W-1:0]   r_lr, r_disc;
    logic [Q_DEPTH-1:0] r_valid;
    logic               r_rd_ok;
    t_scan_ctl          r_tag, n_tag;
    logic               r_tag_q, n_tag_q;
    logic               r_out_valid;
    t_out_item          r_out;

    // Held request fields
    logic               r_req;
    logic [STATE_W-1:0] r_s, r_ns;
    logic [ACT_W-1:0]   r_a, r_rnd;
    logic [VAL_W-1:0]   r_reward;
    logic               r_greedy;

    // Datapath registers
    logic [Q_W-1:0]     r_q, r_keep, r_newq;
    logic [MUL_A_W-1:0] r_tgt;

    logic               accept;
    logic               last_cnt;
    logic               out_free;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               wr_en;
    logic [Q_W-1:0]     ram_rdata, rd_data;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic [Q_W-1:0]     best;
    logic [ACT_W-1:0]   best_idx;
    logic [Q_W+1:0]     q_sum;
    logic [STATE_W-1:0] sel_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign last_cnt   = (r_cnt == ACT_W'(NUM_ACTIONS - 1));
    assign out_free   = !r_out_valid || i_out_ready;
    assign sel_state  = r_req ? r_ns : r_s;
    assign wr_addr    = q_addr(r_s, r_a);

    // Entries never written since reset read as zero
    assign rd_data = r_rd_ok ? ram_rdata : '0;

    assign q_sum = (Q_W + 2)'(r_keep) + (Q_W + 2)'(prod[MUL_P_W-1:FRAC_W]);

    qlt_ram #(
        .WIDTH(Q_W),
        .DEPTH(Q_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(r_newq),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    qlt_mul u_mul (
        .i_clk (i_clk),
        .i_op_a(mul_a),
        .i_op_b(mul_b),
        .o_prod(prod)
    );

    qlt_scan u_scan (
        .i_clk     (i_clk),
        .i_ctl     (r_tag),
        .i_data    (rd_data),
        .o_best    (best),
        .o_best_idx(best_idx)
    );

    // Sequencer: table port, multiplier operands and read tags
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_tag   = '0;
        n_tag_q = 1'b0;
        rd_addr = q_addr(r_s, r_a);
        wr_en   = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = i_in_data.req_type ? S_RDQ : S_SEL;
                end
            end
            S_RDQ: begin
                n_tag_q = 1'b1;
                n_state = S_ROW;
            end
            S_ROW: begin
                rd_addr = q_addr(r_ns, r_cnt);
                n_tag   = '{en: 1'b1, first: (r_cnt == '0), idx: r_cnt};
                if (last_cnt) begin
                    n_cnt   = '0;
                    n_state = S_ROWW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROWW: begin
                n_state = S_M1;
            end
            S_M1: begin
                mul_a   = MUL_A_W'(best);
                mul_b   = MUL_B_W'(r_disc);
                n_state = S_M2;
            end
            S_M2: begin
                mul_a   = MUL_A_W'(r_q);
                mul_b   = ONE_FIX - MUL_B_W'(r_lr);
                n_state = S_M3;
            end
            S_M3: begin
                mul_a   = r_tgt;
                mul_b   = MUL_B_W'(r_lr);
                n_state = S_M4;
            end
            S_M4: begin
                n_state = S_WR;
            end
            S_WR: begin
                wr_en   = 1'b1;
                n_cnt   = '0;
                n_state = S_SEL;
            end
            S_SEL: begin
                rd_addr = q_addr(sel_state, r_cnt);
                n_tag   = '{en: 1'b1, first: (r_cnt == '0), idx: r_cnt};
                if (last_cnt) begin
                    n_cnt   = '0;
                    n_state = S_SELW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SELW: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_tag       <= '0;
            r_tag_q     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_lr        <= LR_RESET;
            r_disc      <= DISC_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_tag   <= n_tag;
            r_tag_q <= n_tag_q;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            // Drop the beat once taken; a fresh load wins
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEARN_RATE: r_lr   <= i_cfg_data;
                    CFG_DISCOUNT:   r_disc <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_valid[rd_addr];
        if (accept) begin
            r_req    <= i_in_data.req_type;
            r_s      <= wrap_state(i_in_data.cur_state);
            r_a      <= wrap_action(i_in_data.taken_action);
            r_ns     <= wrap_state(i_in_data.next_state);
            r_reward <= i_in_data.reward_in;
            r_rnd    <= wrap_action(i_in_data.random_action);
            r_greedy <= (i_in_data.explore_rate < i_in_data.explore_draw);
        end
        if (r_tag_q) begin
            r_q <= rd_data;
        end
        if (r_state == S_M2) begin
            r_tgt <= MUL_A_W'(r_reward) + MUL_A_W'(prod[MUL_P_W-1:FRAC_W]);
        end
        if (r_state == S_M3) begin
            r_keep <= prod[FRAC_W+Q_W-1:FRAC_W];
        end
        if (r_state == S_M4) begin
            r_newq <= (q_sum > (Q_W + 2)'(Q_MAX)) ? Q_MAX : q_sum[Q_W-1:0];
        end
        if (r_state == S_OUT && out_free) begin
            r_out.chosen_action <= r_greedy ? OUT_ACT_W'(best_idx) : OUT_ACT_W'(r_rnd);
            r_out.explored      <= !r_greedy;
            r_out.new_q_value   <= r_req ? r_newq : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/qlt_checker.sv
// Port-level checker of the Q table engine and its bind to the top level.
`include "assert_macros.svh"

module qlt_checker import qlt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_in_valid && o_in_ready && (i_in_data.req_type || !i_in_data.req_type);
    assign out_stall = o_out_valid && !i_out_ready;

    // A request occupies the engine: no second beat in the following cycle
    `QLT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, !o_in_ready, "ready stayed high after a request beat")

    // A result is loaded only from a busy cycle
    `QLT_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result appeared without a busy cycle")

    // A stalled result holds
    `QLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "result beat dropped while stalled")

    `QLT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(o_out_data), "result beat changed while stalled")

endmodule

bind q_learning_table_update qlt_checker u_qlt_checker (.*);
